>>> rtl/cht_pkg.sv
// shared types and constants of the chained hash symbol table
package cht_pkg;

  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 24;
  localparam int FORMAT_W = 4;
  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_DUP      = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic clr_write;
    logic key_load;
    logic sum_load;
    logic hash_step;
    logic head_read;
    logic ptr_from_head;
    logic node_read;
    logic ptr_from_next;
    logic fin_hit;
    logic fin_miss;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_done;
    logic ptr_valid;
    logic key_match;
  } dp_stat_t;

endpackage

>>> rtl/cht_datapath.sv
// datapath: key capture, bucket hash, bucket head and node memories, result registers
module cht_datapath #(
  parameter int BUCKETS   = 64,
  parameter int NODES     = 256,
  parameter int KEY_CHARS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cht_pkg::dp_cmd_t                       cmd,
  output cht_pkg::dp_stat_t                      stat,
  input  logic                                   op_in,
  input  logic [cht_pkg::KEY_W-1:0]              key_in,
  input  logic [cht_pkg::VALUE_W-1:0]            value_in,
  input  logic signed [cht_pkg::FORMAT_W-1:0]    format_in,
  output logic [cht_pkg::STATUS_W-1:0]           status,
  output logic [cht_pkg::VALUE_W-1:0]            found_value,
  output logic signed [cht_pkg::FORMAT_W-1:0]    found_format
);

  localparam int PTR_W  = $clog2(NODES + 1);
  localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SUM_W  = $clog2(KEY_CHARS * 255 + 1);
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NODES);
  localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(BUCKETS - 1);

  logic                                  op_r;
  logic [cht_pkg::KEY_W-1:0]             key_r;
  logic [cht_pkg::VALUE_W-1:0]           value_r;
  logic [cht_pkg::FORMAT_W-1:0]          format_r;
  logic [cht_pkg::KEY_W-1:0]             key_c;
  logic [SUM_W-1:0]                      sum_c;
  logic [BKT_W-1:0]                      bucket;
  logic                                  hash_done;
  logic [BKT_W-1:0]                      clr_idx;
  logic [PTR_W-1:0]                      used;
  logic [PTR_W-1:0]                      ptr;
  logic [PTR_W-1:0]                      head_q;
  logic [cht_pkg::KEY_W-1:0]             nkey_q;
  logic [cht_pkg::VALUE_W-1:0]           nval_q;
  logic [cht_pkg::FORMAT_W-1:0]          nfmt_q;
  logic [PTR_W-1:0]                      nnext_q;
  logic                                  full;
  logic                                  ins_we;

  logic [PTR_W-1:0]                      head_mem [BUCKETS];
  logic [cht_pkg::KEY_W-1:0]             node_key [NODES];
  logic [cht_pkg::VALUE_W-1:0]           node_value [NODES];
  logic [cht_pkg::FORMAT_W-1:0]          node_format [NODES];
  logic [PTR_W-1:0]                      node_next [NODES];

  // key ends at its first zero byte or after KEY_CHARS bytes
  always_comb begin
    logic alive;
    alive = 1'b1;
    key_c = '0;
    for (int i = 0; i < 8; i++) begin
      if (i >= KEY_CHARS || key_in[8*i +: 8] == 8'd0) alive = 1'b0;
      if (alive) key_c[8*i +: 8] = key_in[8*i +: 8];
    end
  end

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < KEY_CHARS; i++) begin
      sum_c = sum_c + SUM_W'(key_r[8*i +: 8]);
    end
  end

  generate
    if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_mask
      logic [BKT_W-1:0] bkt_r;
      always_ff @(posedge clk) begin
        if (cmd.sum_load) bkt_r <= BKT_W'(32'(sum_c) & (BUCKETS - 1));
      end
      assign bucket    = bkt_r;
      assign hash_done = 1'b1;
    end else begin : g_rem
      // remainder by reciprocal multiplication, exact for every sum below 2**SUM_W
      localparam int RS      = SUM_W + BKT_W;
      localparam int RECIP_W = SUM_W + 2;
      localparam int PROD_W  = SUM_W + RECIP_W;
      localparam int QB_W    = SUM_W + BKT_W + 1;
      localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RS) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
      logic [SUM_W-1:0]  sum_r;
      logic [BKT_W-1:0]  rem_r;
      logic              rem_ok;
      logic [PROD_W-1:0] prod;
      logic [SUM_W-1:0]  quo;
      logic [QB_W-1:0]   qb;
      logic [SUM_W-1:0]  rem_c;
      assign prod  = PROD_W'(sum_r) * PROD_W'(RECIP);
      assign quo   = SUM_W'(prod >> RS);
      assign qb    = QB_W'(quo) * QB_W'(BUCKETS);
      assign rem_c = sum_r - SUM_W'(qb);
      always_ff @(posedge clk) begin
        if (rst) begin
          rem_ok <= 1'b0;
        end else if (cmd.sum_load) begin
          rem_ok <= 1'b0;
        end else if (cmd.hash_step) begin
          rem_ok <= 1'b1;
        end
        if (cmd.sum_load) sum_r <= sum_c;
        if (cmd.hash_step) rem_r <= BKT_W'(rem_c);
      end
      assign bucket    = rem_r;
      assign hash_done = rem_ok;
    end
  endgenerate

  assign full   = (used == NULL_PTR);
  assign ins_we = cmd.fin_miss && op_r && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      used    <= '0;
    end else begin
      if (cmd.clr_write) clr_idx <= clr_idx + BKT_W'(1);
      if (ins_we) used <= used + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_load) begin
      op_r     <= op_in;
      key_r    <= key_c;
      value_r  <= value_in;
      format_r <= format_in;
    end
    if (cmd.ptr_from_head) ptr <= head_q;
    else if (cmd.ptr_from_next) ptr <= nnext_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_write) head_mem[clr_idx] <= NULL_PTR;
    else if (ins_we) head_mem[bucket] <= used;
    if (cmd.head_read) head_q <= head_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (ins_we) begin
      node_key[used[NODE_W-1:0]]    <= key_r;
      node_value[used[NODE_W-1:0]]  <= value_r;
      node_format[used[NODE_W-1:0]] <= format_r;
      node_next[used[NODE_W-1:0]]   <= head_q;
    end
    if (cmd.node_read) begin
      nkey_q  <= node_key[ptr[NODE_W-1:0]];
      nval_q  <= node_value[ptr[NODE_W-1:0]];
      nfmt_q  <= node_format[ptr[NODE_W-1:0]];
      nnext_q <= node_next[ptr[NODE_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_hit) begin
      if (op_r) begin
        status       <= cht_pkg::ST_DUP;
        found_value  <= '0;
        found_format <= '0;
      end else begin
        status       <= cht_pkg::ST_HIT;
        found_value  <= nval_q;
        found_format <= nfmt_q;
      end
    end else if (cmd.fin_miss) begin
      found_value  <= '0;
      found_format <= '0;
      if (!op_r) status <= cht_pkg::ST_MISS;
      else if (full) status <= cht_pkg::ST_FULL;
      else status <= cht_pkg::ST_INSERTED;
    end
  end

  assign stat.clr_last  = (clr_idx == LAST_BKT);
  assign stat.hash_done = hash_done;
  assign stat.ptr_valid = (ptr < used);
  assign stat.key_match = (nkey_q == key_r);

endmodule

>>> rtl/cht_ctrl.sv
// controller state machine: head clearing sweep, hash, chain walk, finish
module cht_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output cht_pkg::dp_cmd_t   cmd,
  input  cht_pkg::dp_stat_t  stat
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SUM,
    S_HASH,
    S_HEAD,
    S_LINK,
    S_CHECK,
    S_CMP,
    S_FIN_HIT,
    S_FIN_MISS
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.key_load = 1'b1;
          state_next   = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_load = 1'b1;
        state_next   = S_HASH;
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (stat.hash_done) state_next = S_HEAD;
      end
      S_HEAD: begin
        cmd.head_read = 1'b1;
        state_next    = S_LINK;
      end
      S_LINK: begin
        cmd.ptr_from_head = 1'b1;
        state_next        = S_CHECK;
      end
      S_CHECK: begin
        if (stat.ptr_valid) begin
          cmd.node_read = 1'b1;
          state_next    = S_CMP;
        end else begin
          state_next = S_FIN_MISS;
        end
      end
      S_CMP: begin
        if (stat.key_match) begin
          state_next = S_FIN_HIT;
        end else begin
          cmd.ptr_from_next = 1'b1;
          state_next        = S_CHECK;
        end
      end
      S_FIN_HIT: begin
        cmd.fin_hit = 1'b1;
        state_next  = S_IDLE;
      end
      S_FIN_MISS: begin
        cmd.fin_miss = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state == S_FIN_HIT) || (state == S_FIN_MISS);
    end
  end

endmodule

>>> rtl/chained_hash_symbol_table.sv
// top level of the chained hash symbol table
// a lookup or insert keeps busy high from its transfer until its result is registered: sum, hash,
// bucket head read, then a pointer check and key compare per chain node; hashing takes longer when
// BUCKETS is not a power of two; done strobes the result in the first idle cycle, which also takes
// the next start, so an item is not taken before the last one completes; the receiver cannot stall results
// after reset busy stays high while the bucket heads are swept to empty
module chained_hash_symbol_table #(
  parameter int BUCKETS   = 64,
  parameter int NODES     = 256,
  parameter int KEY_CHARS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op,
  input  logic [cht_pkg::KEY_W-1:0]           key,
  input  logic [cht_pkg::VALUE_W-1:0]         value,
  input  logic signed [cht_pkg::FORMAT_W-1:0] format,
  output logic                                done,
  output logic [cht_pkg::STATUS_W-1:0]        status,
  output logic [cht_pkg::VALUE_W-1:0]         found_value,
  output logic signed [cht_pkg::FORMAT_W-1:0] found_format
);

  cht_pkg::dp_cmd_t  cmd;
  cht_pkg::dp_stat_t stat;

  cht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  cht_datapath #(
    .BUCKETS   (BUCKETS),
    .NODES     (NODES),
    .KEY_CHARS (KEY_CHARS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op_in        (op),
    .key_in       (key),
    .value_in     (value),
    .format_in    (format),
    .status       (status),
    .found_value  (found_value),
    .found_format (found_format)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an input transfer");

  a_nonhit_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != cht_pkg::ST_HIT) |-> (found_value == '0 && found_format == '0))
    else $error("non-hit result carries value or format");

  a_no_double_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result strobes for one item");

endmodule
